FILE: sv/boundary_tag_first_fit_allocator_macros.svh
// Assertion macros shared by the checker of the allocator.
// No dependencies; included by files that hold concurrent assertions.
`ifndef BOUNDARY_TAG_FIRST_FIT_ALLOCATOR_MACROS_SVH
`define BOUNDARY_TAG_FIRST_FIT_ALLOCATOR_MACROS_SVH

// Same-cycle implication, checked while reset is released.
`define BTFF_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("allocator check failed");

// Next-cycle implication, checked while reset is released.
`define BTFF_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("allocator check failed");

`endif

FILE: sv/btff_pkg.sv
// Package of the boundary-tag allocator: arena constants, tag format, bus types.
// No dependencies; used by the controller and the top level.
package btff_pkg;

  localparam int ARENA_BYTES   = 65536;
  localparam int HEADER_BYTES  = 32;
  localparam int FOOTER_BYTES  = 16;
  localparam int MIN_REMAINDER = 56;

  localparam int ARENA_USE = (ARENA_BYTES / 8) * 8;
  localparam int TAG_DEPTH = ARENA_USE / 8;
  localparam int ADDR_W    = $clog2(TAG_DEPTH);
  localparam int SIZE_W    = 17;
  localparam int TAG_W     = SIZE_W + 1;
  localparam int OFF_W     = 16;
  localparam int ROUND_W   = SIZE_W + 1;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic ST_DONE  = 1'b0;
  localparam logic ST_NOFIT = 1'b1;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [TAG_W-1:0]  wdata;
  } mem_req_t;

  function automatic logic [TAG_W-1:0] mk_tag(input logic [SIZE_W-1:0] size,
                                              input logic alloc);
    mk_tag = {size[SIZE_W-1:3], 3'b000, alloc};
  endfunction

  function automatic logic [SIZE_W-1:0] tag_size(input logic [TAG_W-1:0] tag);
    tag_size = {tag[TAG_W-1:4], 3'b000};
  endfunction

  function automatic logic [ADDR_W-1:0] gaddr(input logic [ROUND_W-1:0] offset);
    gaddr = offset[ADDR_W+2:3];
  endfunction

endpackage

FILE: sv/btff_ram.sv
// Single-port tag memory with a registered read, one tag per 8-byte granule.
// No dependencies; instantiated by the allocator top level.
module btff_ram #(
  parameter int DEPTH  = 8192,
  parameter int WIDTH  = 18,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] addr,
  input  logic [WIDTH-1:0]  wdata,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end

  assign rdata = rdata_r;

endmodule

FILE: sv/btff_ctrl.sv
// Sequencer of the allocator: walks block tags, splits, merges and writes tags back.
// Depends on btff_pkg; drives the tag memory through a btff_pkg::mem_req_t.
module btff_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [39:0]                   in_tdata,
  input  logic                          in_tuser,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [39:0]                   out_tdata,
  output logic                          out_tuser,
  output btff_pkg::mem_req_t            mem_req,
  input  logic [btff_pkg::TAG_W-1:0]    mem_rdata
);
  import btff_pkg::*;

  localparam logic [3:0] S_INIT0  = 4'd0;
  localparam logic [3:0] S_INIT1  = 4'd1;
  localparam logic [3:0] S_IDLE   = 4'd2;
  localparam logic [3:0] S_A_RD   = 4'd3;
  localparam logic [3:0] S_A_CHK  = 4'd4;
  localparam logic [3:0] S_F_WRD  = 4'd5;
  localparam logic [3:0] S_F_WCHK = 4'd6;
  localparam logic [3:0] S_F_CHK  = 4'd7;
  localparam logic [3:0] S_F_HDR  = 4'd8;
  localparam logic [3:0] S_F_NXT  = 4'd9;
  localparam logic [3:0] S_F_PRV  = 4'd10;
  localparam logic [3:0] S_WR     = 4'd11;

  localparam logic [ROUND_W-1:0] ARENA_R = ROUND_W'(ARENA_USE);
  localparam logic [ROUND_W-1:0] GRAN_R  = ROUND_W'(8);
  localparam logic [ROUND_W-1:0] OVH_R   = ROUND_W'(HEADER_BYTES + FOOTER_BYTES + 7);
  localparam logic [OFF_W-1:0]   HDR_O   = OFF_W'(HEADER_BYTES);

  logic [3:0]         state_r, state_nxt;
  logic [SIZE_W-1:0]  pos_r, pos_nxt;
  logic [OFF_W-1:0]   start_r, start_nxt;
  logic [ROUND_W-1:0] rounded_r, rounded_nxt;
  logic [SIZE_W-1:0]  nsize_r, nsize_nxt;
  logic [OFF_W-1:0]   nstart_r, nstart_nxt;
  logic [ADDR_W-1:0]  wr_addr_r [4];
  logic [ADDR_W-1:0]  wr_addr_nxt [4];
  logic [TAG_W-1:0]   wr_tag_r [4];
  logic [TAG_W-1:0]   wr_tag_nxt [4];
  logic [1:0]         wr_idx_r, wr_idx_nxt;
  logic [1:0]         wr_last_r, wr_last_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [OFF_W-1:0]   res_off_r, res_off_nxt;
  logic [SIZE_W-1:0]  res_bytes_r, res_bytes_nxt;
  logic               res_stat_r, res_stat_nxt;

  logic [SIZE_W-1:0]  rd_size;
  logic               rd_alloc;
  logic [SIZE_W-1:0]  req_bytes;
  logic [OFF_W-1:0]   pay_off;

  assign rd_size   = tag_size(mem_rdata);
  assign rd_alloc  = mem_rdata[0];
  assign req_bytes = in_tdata[16:0];
  assign pay_off   = in_tdata[32:17];

  always_comb begin
    logic signed [ROUND_W:0] diff;
    logic [ROUND_W-1:0]      pos_e;
    logic [ROUND_W-1:0]      sum;
    logic [ROUND_W-1:0]      merged;
    logic [SIZE_W-1:0]       fsize;
    logic [OFF_W-1:0]        fstart;
    logic                    fail;
    logic                    fwrite;

    state_nxt     = state_r;
    pos_nxt       = pos_r;
    start_nxt     = start_r;
    rounded_nxt   = rounded_r;
    nsize_nxt     = nsize_r;
    nstart_nxt    = nstart_r;
    wr_addr_nxt   = wr_addr_r;
    wr_tag_nxt    = wr_tag_r;
    wr_idx_nxt    = wr_idx_r;
    wr_last_nxt   = wr_last_r;
    out_valid_nxt = out_valid_r;
    res_off_nxt   = res_off_r;
    res_bytes_nxt = res_bytes_r;
    res_stat_nxt  = res_stat_r;
    mem_req       = '0;
    pos_e         = {1'b0, pos_r};
    diff          = $signed({2'b00, rd_size}) - $signed({1'b0, rounded_r});
    sum           = '0;
    merged        = '0;
    fsize         = nsize_r;
    fstart        = nstart_r;
    fail          = 1'b0;
    fwrite        = 1'b0;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_INIT0: begin
        mem_req.we    = 1'b1;
        mem_req.addr  = '0;
        mem_req.wdata = mk_tag(SIZE_W'(ARENA_USE), 1'b0);
        state_nxt     = S_INIT1;
      end
      S_INIT1: begin
        mem_req.we    = 1'b1;
        mem_req.addr  = ADDR_W'(TAG_DEPTH - 1);
        mem_req.wdata = mk_tag(SIZE_W'(ARENA_USE), 1'b0);
        state_nxt     = S_IDLE;
      end
      S_IDLE: begin
        if (in_tvalid && in_tready) begin
          pos_nxt = '0;
          if (in_tuser == OP_ALLOC) begin
            rounded_nxt = ({1'b0, req_bytes} + OVH_R) & ~ROUND_W'(7);
            state_nxt   = S_A_RD;
          end else if (pay_off < HDR_O) begin
            fail = 1'b1;
          end else begin
            start_nxt = pay_off - HDR_O;
            state_nxt = S_F_WRD;
          end
        end
      end
      S_A_RD: begin
        if (pos_e >= ARENA_R) begin
          fail = 1'b1;
        end else begin
          mem_req.addr = gaddr(pos_e);
          state_nxt    = S_A_CHK;
        end
      end
      S_A_CHK: begin
        if (rd_size == '0) begin
          fail = 1'b1;
        end else if (!rd_alloc && diff > (ROUND_W+1)'(MIN_REMAINDER)) begin
          sum            = pos_e + rounded_r;
          wr_addr_nxt[0] = gaddr(pos_e);
          wr_addr_nxt[1] = gaddr(sum - GRAN_R);
          wr_addr_nxt[2] = gaddr(sum);
          wr_addr_nxt[3] = gaddr(pos_e + {1'b0, rd_size} - GRAN_R);
          wr_tag_nxt[0]  = mk_tag(rounded_r[SIZE_W-1:0], 1'b1);
          wr_tag_nxt[1]  = mk_tag(rounded_r[SIZE_W-1:0], 1'b1);
          wr_tag_nxt[2]  = mk_tag(rd_size - rounded_r[SIZE_W-1:0], 1'b0);
          wr_tag_nxt[3]  = mk_tag(rd_size - rounded_r[SIZE_W-1:0], 1'b0);
          wr_idx_nxt     = '0;
          wr_last_nxt    = 2'd3;
          res_off_nxt    = pos_r[OFF_W-1:0] + HDR_O;
          res_bytes_nxt  = rounded_r[SIZE_W-1:0];
          res_stat_nxt   = ST_DONE;
          state_nxt      = S_WR;
        end else if (!rd_alloc && diff >= 0) begin
          wr_addr_nxt[0] = gaddr(pos_e);
          wr_addr_nxt[1] = gaddr(pos_e + {1'b0, rd_size} - GRAN_R);
          wr_tag_nxt[0]  = mk_tag(rd_size, 1'b1);
          wr_tag_nxt[1]  = mk_tag(rd_size, 1'b1);
          wr_idx_nxt     = '0;
          wr_last_nxt    = 2'd1;
          res_off_nxt    = pos_r[OFF_W-1:0] + HDR_O;
          res_bytes_nxt  = rd_size;
          res_stat_nxt   = ST_DONE;
          state_nxt      = S_WR;
        end else begin
          pos_nxt   = pos_r + rd_size;
          state_nxt = S_A_RD;
        end
      end
      S_F_WRD: begin
        if (pos_r >= {1'b0, start_r}) begin
          state_nxt = S_F_CHK;
        end else begin
          mem_req.addr = gaddr(pos_e);
          state_nxt    = S_F_WCHK;
        end
      end
      S_F_WCHK: begin
        if (rd_size == '0) begin
          state_nxt = S_F_CHK;
        end else begin
          pos_nxt   = pos_r + rd_size;
          state_nxt = S_F_WRD;
        end
      end
      S_F_CHK: begin
        if (pos_r != {1'b0, start_r}) begin
          fail = 1'b1;
        end else begin
          mem_req.addr = gaddr({2'b00, start_r});
          state_nxt    = S_F_HDR;
        end
      end
      S_F_HDR: begin
        if (!rd_alloc) begin
          fail = 1'b1;
        end else begin
          nsize_nxt  = rd_size;
          nstart_nxt = start_r;
          fsize      = rd_size;
          fstart     = start_r;
          sum        = {2'b00, start_r} + {1'b0, rd_size};
          if (sum < ARENA_R) begin
            mem_req.addr = gaddr(sum);
            state_nxt    = S_F_NXT;
          end else if (start_r >= OFF_W'(8)) begin
            mem_req.addr = gaddr({2'b00, start_r} - GRAN_R);
            state_nxt    = S_F_PRV;
          end else begin
            fwrite = 1'b1;
          end
        end
      end
      S_F_NXT: begin
        fsize = nsize_r;
        if (!rd_alloc) begin
          fsize = nsize_r + rd_size;
        end
        nsize_nxt = fsize;
        if (start_r >= OFF_W'(8)) begin
          mem_req.addr = gaddr({2'b00, start_r} - GRAN_R);
          state_nxt    = S_F_PRV;
        end else begin
          fwrite = 1'b1;
        end
      end
      S_F_PRV: begin
        if (!rd_alloc && rd_size <= {1'b0, start_r}) begin
          fstart = start_r - rd_size[OFF_W-1:0];
          fsize  = nsize_r + rd_size;
        end
        fwrite = 1'b1;
      end
      S_WR: begin
        mem_req.we    = 1'b1;
        mem_req.addr  = wr_addr_r[wr_idx_r];
        mem_req.wdata = wr_tag_r[wr_idx_r];
        if (wr_idx_r == wr_last_r) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          wr_idx_nxt = wr_idx_r + 2'd1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (fwrite) begin
      merged         = {2'b00, fstart} + {1'b0, fsize} - GRAN_R;
      wr_addr_nxt[0] = gaddr({2'b00, fstart});
      wr_addr_nxt[1] = gaddr(merged);
      wr_tag_nxt[0]  = mk_tag(fsize, 1'b0);
      wr_tag_nxt[1]  = mk_tag(fsize, 1'b0);
      wr_idx_nxt     = '0;
      wr_last_nxt    = 2'd1;
      res_off_nxt    = '0;
      res_bytes_nxt  = '0;
      res_stat_nxt   = ST_DONE;
      state_nxt      = S_WR;
    end

    if (fail) begin
      res_off_nxt   = '0;
      res_bytes_nxt = '0;
      res_stat_nxt  = ST_NOFIT;
      out_valid_nxt = 1'b1;
      state_nxt     = S_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    pos_r       <= pos_nxt;
    start_r     <= start_nxt;
    rounded_r   <= rounded_nxt;
    nsize_r     <= nsize_nxt;
    nstart_r    <= nstart_nxt;
    wr_addr_r   <= wr_addr_nxt;
    wr_tag_r    <= wr_tag_nxt;
    wr_idx_r    <= wr_idx_nxt;
    wr_last_r   <= wr_last_nxt;
    res_off_r   <= res_off_nxt;
    res_bytes_r <= res_bytes_nxt;
    res_stat_r  <= res_stat_nxt;
  end

  assign in_tready  = (state_r == S_IDLE) && !out_valid_r;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'b0, res_bytes_r, res_off_r};
  assign out_tuser  = res_stat_r;

endmodule

FILE: sv/boundary_tag_first_fit_allocator.sv
// Channel   Dir  tdata (lowest bit up)                        tuser
// in_       in   request_bytes[16:0], payload_offset[32:17]   op
// out_      out  granted_offset[15:0], granted_bytes[32:16]   status
// After its transfer an allocate reads and checks the tag of each block walked, then makes 2 or
// 4 tag writes on a fit or gives its result on no fit. A free walks the blocks before it, then
// makes up to three tag reads and 2 tag writes; the single tag memory port serializes them.
// After reset S_INIT0 and S_INIT1 write the two arena tags; in_tready stays low until then, while
// a request is in progress and while a result waits for its transfer.
// Top level of the allocator; depends on btff_pkg, btff_ctrl and btff_ram.
module boundary_tag_first_fit_allocator (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // request_bytes, payload_offset
  input  logic        in_tuser,   // op
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // granted_offset, granted_bytes
  output logic        out_tuser   // status
);
  import btff_pkg::*;

  mem_req_t         mem_req;
  logic [TAG_W-1:0] mem_rdata;

  btff_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .mem_req    (mem_req),
    .mem_rdata  (mem_rdata)
  );

  btff_ram #(
    .DEPTH  (TAG_DEPTH),
    .WIDTH  (TAG_W),
    .ADDR_W (ADDR_W)
  ) u_ram (
    .clk   (clk),
    .we    (mem_req.we),
    .addr  (mem_req.addr),
    .wdata (mem_req.wdata),
    .rdata (mem_rdata)
  );

endmodule

FILE: sv/btff_chk.sv
// Port-level checker of the allocator, bound to the top level.
// Depends on the macros header; watches only the top-level ports.
`include "boundary_tag_first_fit_allocator_macros.svh"

module btff_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [39:0] out_tdata,
  input logic        out_tuser
);

  `BTFF_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid)
  `BTFF_ASSERT_NEXT(a_one_item, in_tvalid && in_tready, !in_tready)
  `BTFF_ASSERT_NOW(a_nofit_zero, out_tvalid && out_tuser, out_tdata[32:0] == 33'd0)
  `BTFF_ASSERT_NOW(a_granule, out_tvalid, out_tdata[2:0] == 3'd0 && out_tdata[18:16] == 3'd0)
  `BTFF_ASSERT_NOW(a_min_block, out_tvalid && out_tdata[32:16] != 17'd0,
                   out_tdata[32:16] >= 17'd48)

endmodule

bind boundary_tag_first_fit_allocator btff_chk u_chk (.*);
